// File: sv/c_source_lexer_assert.svh
// Assertion macros shared by the lexer modules.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef C_SOURCE_LEXER_ASSERT_SVH
`define C_SOURCE_LEXER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSLX_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSLX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/cslx_pkg.sv
// Shared types, byte and class codes, and helpers for the source lexer.
// No dependencies.
`default_nettype none
package cslx_pkg;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] lexeme_byte;
    logic [3:0] token_class;
    logic       last_of_input;
  } out_word_t;

  typedef struct packed {
    logic       item_kind;
    logic [7:0] lexeme_byte;
    logic [3:0] token_class;
  } res_t;

  typedef struct packed {
    logic       eos;
    logic [1:0] nfeed;
    logic [7:0] c0;
    logic [7:0] c1;
  } cmd_t;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = Q_AW + 1;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  localparam logic [3:0] CL_NEWLINE  = 4'd0;
  localparam logic [3:0] CL_OPERATOR = 4'd1;
  localparam logic [3:0] CL_CBEGIN   = 4'd2;
  localparam logic [3:0] CL_LINECMT  = 4'd3;
  localparam logic [3:0] CL_COMMENT  = 4'd4;
  localparam logic [3:0] CL_CEND     = 4'd5;
  localparam logic [3:0] CL_DQ       = 4'd6;
  localparam logic [3:0] CL_SQ       = 4'd7;
  localparam logic [3:0] CL_SPACE    = 4'd8;
  localparam logic [3:0] CL_SYMBOL   = 4'd9;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
  endfunction

  function automatic res_t mk_put(input logic [7:0] b);
    res_t r;
    r.item_kind   = 1'b0;
    r.lexeme_byte = b;
    r.token_class = 4'd0;
    return r;
  endfunction

  function automatic res_t mk_fin(input logic [3:0] cls);
    res_t r;
    r.item_kind   = 1'b1;
    r.lexeme_byte = 8'd0;
    r.token_class = cls;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/cslx_front.sv
// Front end: accepts source words, drops carriage returns and splices
// backslash-newline pairs. Depends on cslx_pkg.
`default_nettype none
module cslx_front (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  cslx_pkg::in_word_t in_data,
  output logic              push_valid,
  input  wire               push_ready,
  output cslx_pkg::cmd_t    push_cmd
);
  import cslx_pkg::*;

  logic held_r;
  logic held_nxt;
  logic need_push;
  logic accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    push_cmd    = '0;
    push_cmd.c0 = in_data.char_in;
    push_cmd.c1 = in_data.char_in;
    need_push   = 1'b0;
    held_nxt    = held_r;
    priority if (in_data.end_of_stream) begin
      push_cmd.eos   = 1'b1;
      push_cmd.nfeed = held_r ? 2'd1 : 2'd0;
      push_cmd.c0    = CH_BSLASH;
      need_push      = 1'b1;
      held_nxt       = 1'b0;
    end else if (in_data.char_in == CH_CR) begin
      need_push = 1'b0;
    end else if (held_r) begin
      held_nxt    = 1'b0;
      push_cmd.c0 = CH_BSLASH;
      if (in_data.char_in == CH_BSLASH) begin
        push_cmd.nfeed = 2'd1;
        need_push      = 1'b1;
        held_nxt       = 1'b1;
      end else if (in_data.char_in != CH_LF) begin
        push_cmd.nfeed = 2'd2;
        need_push      = 1'b1;
      end
    end else if (in_data.char_in == CH_BSLASH) begin
      held_nxt = 1'b1;
    end else begin
      push_cmd.nfeed = 2'd1;
      need_push      = 1'b1;
    end
  end

  assign push_valid = in_valid && need_push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else if (accept) begin
      held_r <= held_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/cslx_queue.sv
// Short command queue between the front end and the lexer engine.
// Depends on cslx_pkg and c_source_lexer_assert.svh.
`default_nettype none
`include "c_source_lexer_assert.svh"
module cslx_queue (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            push_valid,
  output logic           push_ready,
  input  cslx_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  wire            pop_ready,
  output cslx_pkg::cmd_t pop_cmd
);
  import cslx_pkg::*;

  cmd_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_CW-1:0] cnt_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (cnt_r != Q_CW'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  `CSLX_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_r <= Q_CW'(Q_DEPTH), "queue count overflow")

endmodule
`default_nettype wire

// File: sv/cslx_back.sv
// Lexer engine: runs lexer passes on queued bytes, one result word of a pass at a time,
// and streams result words through a pending stage and an output register.
// Depends on cslx_pkg and c_source_lexer_assert.svh.
`default_nettype none
`include "c_source_lexer_assert.svh"
module cslx_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cmd_valid,
  output logic               cmd_ready,
  input  cslx_pkg::cmd_t     cmd,
  output logic               out_valid,
  input  wire                out_ready,
  output cslx_pkg::out_word_t out_data
);
  import cslx_pkg::*;

  typedef enum logic [3:0] {
    ST_START     = 4'd0,
    ST_SLASH     = 4'd1,
    ST_LINECMT   = 4'd2,
    ST_BLOCK     = 4'd3,
    ST_BLOCKSTAR = 4'd4,
    ST_DQ        = 4'd5,
    ST_SQ        = 4'd6,
    ST_SPACE     = 4'd7,
    ST_SYMBOL    = 4'd8,
    ST_DQESC     = 4'd9,
    ST_SQESC     = 4'd10
  } lex_state_t;

  lex_state_t st_r;
  logic       ne_r;
  logic [1:0] fi_r;
  logic [1:0] pc_r;
  logic [1:0] k_r;
  logic       pend_v_r;
  logic       pend_last_r;
  res_t       pend_res_r;
  logic       out_v_r;
  out_word_t  out_data_r;

  res_t       pr [4];
  logic [1:0] p_n;
  lex_state_t ns;
  logic       nne;
  logic       cons;
  logic [7:0] cc;
  logic [3:0] str_cl;
  logic [7:0] quote;

  logic feeding;
  logic sub_last;
  logic have_res;
  logic out_free;
  logic can_place;
  logic step;
  logic place;
  logic pass_end;
  logic feed_end;
  logic last_feed;
  logic done;
  logic pend_move;

  assign cc     = (fi_r == 2'd0) ? cmd.c0 : cmd.c1;
  assign str_cl = (st_r == ST_DQ || st_r == ST_DQESC) ? CL_DQ : CL_SQ;
  assign quote  = (st_r == ST_DQ) ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    pr    = '{default: '0};
    p_n   = 2'd0;
    ns    = st_r;
    nne   = ne_r;
    cons  = 1'b1;
    unique case (st_r)
      ST_START: begin
        priority if (cc == CH_SLASH) begin
          pr[0] = mk_put(cc); p_n = 2'd1; nne = 1'b1; ns = ST_SLASH;
        end else if (cc == CH_DQUOTE) begin
          pr[0] = mk_put(cc); p_n = 2'd1; nne = 1'b1; ns = ST_DQ;
        end else if (cc == CH_SQUOTE) begin
          pr[0] = mk_put(cc); p_n = 2'd1; nne = 1'b1; ns = ST_SQ;
        end else if (cc == CH_LF) begin
          pr[0] = mk_put(cc); pr[1] = mk_fin(CL_NEWLINE); p_n = 2'd2; nne = 1'b0;
        end else if (is_blank(cc)) begin
          pr[0] = mk_put(cc); p_n = 2'd1; nne = 1'b1; ns = ST_SPACE;
        end else if (is_word(cc)) begin
          pr[0] = mk_put(cc); p_n = 2'd1; nne = 1'b1; ns = ST_SYMBOL;
        end else if (cc == CH_NUL) begin
          p_n = 2'd0;
        end else begin
          pr[0] = mk_put(cc); pr[1] = mk_fin(CL_OPERATOR); p_n = 2'd2; nne = 1'b0;
        end
      end
      ST_SLASH: begin
        priority if (cc == CH_SLASH) begin
          pr[0] = mk_put(cc); p_n = 2'd1; nne = 1'b1; ns = ST_LINECMT;
        end else if (cc == CH_STAR) begin
          pr[0] = mk_put(cc); pr[1] = mk_fin(CL_CBEGIN); p_n = 2'd2; nne = 1'b0;
          ns = ST_BLOCK;
        end else begin
          pr[0] = mk_fin(CL_OPERATOR); p_n = 2'd1; nne = 1'b0; ns = ST_START;
          cons = 1'b0;
        end
      end
      ST_LINECMT: begin
        priority if (cc == CH_LF) begin
          pr[0] = mk_fin(CL_LINECMT); p_n = 2'd1; nne = 1'b0; ns = ST_START;
          cons = 1'b0;
        end else if (cc == CH_NUL) begin
          pr[0] = mk_fin(CL_LINECMT); p_n = 2'd1; nne = 1'b0; ns = ST_START;
        end else begin
          pr[0] = mk_put(cc); p_n = 2'd1; nne = 1'b1;
        end
      end
      ST_BLOCK: begin
        priority if (cc == CH_STAR) begin
          ns = ST_BLOCKSTAR;
        end else if (cc == CH_LF) begin
          if (!ne_r) begin
            pr[0] = mk_put(cc); pr[1] = mk_fin(CL_NEWLINE); p_n = 2'd2; nne = 1'b0;
          end else begin
            pr[0] = mk_fin(CL_COMMENT); p_n = 2'd1; nne = 1'b0; cons = 1'b0;
          end
        end else if (cc == CH_NUL) begin
          ns = ST_START;
        end else begin
          pr[0] = mk_put(cc); p_n = 2'd1; nne = 1'b1;
        end
      end
      ST_BLOCKSTAR: begin
        priority if (cc == CH_STAR) begin
          pr[0] = mk_put(CH_STAR); p_n = 2'd1; nne = 1'b1;
        end else if (cc == CH_SLASH) begin
          if (!ne_r) begin
            pr[0] = mk_put(CH_STAR); pr[1] = mk_put(CH_SLASH); pr[2] = mk_fin(CL_CEND);
            p_n = 2'd3; nne = 1'b0; ns = ST_START;
          end else begin
            pr[0] = mk_fin(CL_COMMENT); p_n = 2'd1; nne = 1'b0; cons = 1'b0;
          end
        end else if (cc == CH_LF) begin
          pr[0] = mk_put(CH_STAR); pr[1] = mk_fin(CL_COMMENT); p_n = 2'd2; nne = 1'b0;
          ns = ST_BLOCK; cons = 1'b0;
        end else if (cc == CH_NUL) begin
          pr[0] = mk_put(CH_STAR); pr[1] = mk_fin(CL_COMMENT); p_n = 2'd2; nne = 1'b0;
          ns = ST_START; cons = 1'b0;
        end else begin
          // The star itself is not kept when an ordinary byte follows it.
          pr[0] = mk_put(cc); p_n = 2'd1; nne = 1'b1; ns = ST_BLOCK;
        end
      end
      ST_DQ, ST_SQ: begin
        priority if (cc == quote) begin
          pr[0] = mk_put(cc); pr[1] = mk_fin(str_cl); p_n = 2'd2; nne = 1'b0;
          ns = ST_START;
        end else if (cc == CH_LF) begin
          pr[0] = mk_fin(str_cl); p_n = 2'd1; nne = 1'b0; ns = ST_START; cons = 1'b0;
        end else if (cc == CH_BSLASH) begin
          pr[0] = mk_put(cc); p_n = 2'd1; nne = 1'b1;
          ns = (st_r == ST_DQ) ? ST_DQESC : ST_SQESC;
        end else if (cc == CH_NUL) begin
          pr[0] = mk_fin(str_cl); p_n = 2'd1; nne = 1'b0; ns = ST_START;
        end else begin
          pr[0] = mk_put(cc); p_n = 2'd1; nne = 1'b1;
        end
      end
      ST_SPACE: begin
        if (is_blank(cc)) begin
          pr[0] = mk_put(cc); p_n = 2'd1; nne = 1'b1;
        end else begin
          pr[0] = mk_fin(CL_SPACE); p_n = 2'd1; nne = 1'b0; ns = ST_START; cons = 1'b0;
        end
      end
      ST_SYMBOL: begin
        if (is_word(cc)) begin
          pr[0] = mk_put(cc); p_n = 2'd1; nne = 1'b1;
        end else begin
          pr[0] = mk_fin(CL_SYMBOL); p_n = 2'd1; nne = 1'b0; ns = ST_START; cons = 1'b0;
        end
      end
      ST_DQESC, ST_SQESC: begin
        priority if (cc == CH_LF) begin
          pr[0] = mk_fin(str_cl); p_n = 2'd1; nne = 1'b0; ns = ST_START; cons = 1'b0;
        end else if (cc == CH_NUL) begin
          pr[0] = mk_fin(str_cl); p_n = 2'd1; nne = 1'b0; ns = ST_START;
        end else begin
          pr[0] = mk_put(cc); p_n = 2'd1; nne = 1'b1;
          ns = (st_r == ST_DQESC) ? ST_DQ : ST_SQ;
        end
      end
      default: begin
        ns = ST_START;
      end
    endcase
  end

  assign feeding   = (fi_r < cmd.nfeed);
  assign sub_last  = (p_n == 2'd0) || (k_r == (p_n - 2'd1));
  assign have_res  = cmd_valid && feeding && (p_n != 2'd0);
  assign out_free  = !out_v_r || out_ready;
  assign can_place = !pend_v_r || out_free;
  assign step      = cmd_valid && (!have_res || can_place);
  assign place     = step && have_res;
  assign pass_end  = step && feeding && sub_last;
  assign feed_end  = pass_end && (cons || (pc_r == 2'd2));
  assign last_feed = ((fi_r + 2'd1) == cmd.nfeed);
  assign done      = step && (!feeding || (feed_end && last_feed));
  assign pend_move = pend_v_r && out_free && (pend_last_r || place);

  assign cmd_ready = done;
  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_START;
      ne_r        <= 1'b0;
      fi_r        <= 2'd0;
      pc_r        <= 2'd0;
      k_r         <= 2'd0;
      pend_v_r    <= 1'b0;
      pend_last_r <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (step && feeding) begin
        if (!sub_last) begin
          k_r <= k_r + 2'd1;
        end else begin
          k_r  <= 2'd0;
          st_r <= ns;
          ne_r <= nne;
          if (feed_end) begin
            pc_r <= 2'd0;
            fi_r <= fi_r + 2'd1;
          end else begin
            pc_r <= pc_r + 2'd1;
          end
        end
      end
      if (done) begin
        fi_r <= 2'd0;
        pc_r <= 2'd0;
        k_r  <= 2'd0;
        if (cmd.eos) begin
          st_r <= ST_START;
          ne_r <= 1'b0;
        end
      end

      if (place) begin
        pend_v_r    <= 1'b1;
        pend_last_r <= done;
      end else if (pend_move) begin
        pend_v_r    <= 1'b0;
        pend_last_r <= 1'b0;
      end else if (done && pend_v_r) begin
        pend_last_r <= 1'b1;
      end

      if (pend_move) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (place) begin
      pend_res_r <= pr[k_r];
    end
    if (pend_move) begin
      out_data_r.item_kind     <= pend_res_r.item_kind;
      out_data_r.lexeme_byte   <= pend_res_r.lexeme_byte;
      out_data_r.token_class   <= pend_res_r.token_class;
      out_data_r.last_of_input <= pend_last_r;
    end
  end

  `CSLX_ASSERT_SAME(a_sub_in_pass, cmd_valid && feeding && (k_r != 2'd0), k_r < p_n, "result index beyond pass")
  `CSLX_ASSERT_NEXT(a_done_clears, done, (fi_r == 2'd0) && (pc_r == 2'd0) && (k_r == 2'd0), "engine not cleared after word")
  `CSLX_ASSERT_SAME(a_pend_owner, pend_v_r && !pend_last_r, cmd_valid, "open pending word without command")

endmodule
`default_nettype wire

// File: sv/c_source_lexer.sv
// Channel   | Ports                             | Word
// input     | in_valid, in_ready, in_data       | cslx_pkg::in_word_t, one source byte
// result    | out_valid, out_ready, out_data    | cslx_pkg::out_word_t, byte or token end
//
// The front end takes one input word per cycle while the command queue has room.
// The lexer engine emits at most one result word per cycle while the pending register
// can take it, and steps through the result words of each lexer pass in turn; a pass
// that gives none still takes a step of its own. The single result port of the engine
// sets this limit.
// Results go through a pending register and an output register, so a stalled
// result port does not block input until the queue fills. Reset is synchronous.
// Top level of the source lexer. Depends on cslx_pkg, cslx_front, cslx_queue
// and cslx_back.
`default_nettype none
module c_source_lexer (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  cslx_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output cslx_pkg::out_word_t out_data
);
  import cslx_pkg::*;

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  cslx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  cslx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  cslx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: tb/cslx_token_checker.sv
// Checker for the source lexer: predicts the result words from each accepted input word
// and compares them with the result channel. Depends on cslx_pkg.
`timescale 1ns / 1ps
module cslx_token_checker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_ready,
  input  cslx_pkg::in_word_t  in_data,
  input  wire                 out_valid,
  input  wire                 out_ready,
  input  cslx_pkg::out_word_t out_data,
  output int                  pending_words,
  output int                  fail_count
);
  import cslx_pkg::*;

  typedef enum logic [3:0] {
    LX_START, LX_SLASH, LX_LINE_CMT, LX_BLOCK, LX_BLOCK_STAR, LX_DQ, LX_SQ,
    LX_SPACE, LX_SYMBOL, LX_DQ_ESC, LX_SQ_ESC
  } lex_state_e;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;
  localparam int   MAX_WORDS_PER_ITEM = 8;
  localparam int   MAX_PRINTED = 30;

  lex_state_e lx_state;
  logic       bs_held;
  logic       lexeme_open;
  int         words_this_item;
  int         mismatch_count = 0;
  int         results_seen = 0;
  out_word_t  expected_words[$];

  function automatic logic blank_byte(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB};
  endfunction

  function automatic logic word_byte(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) || c == CH_UNDER;
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    out_word_t w;
    if (words_this_item < MAX_WORDS_PER_ITEM) begin
      w.item_kind = KIND_BYTE;
      w.lexeme_byte = b;
      w.token_class = '0;
      w.last_of_input = 1'b0;
      expected_words.push_back(w);
      words_this_item++;
    end
    lexeme_open = 1'b1;
  endfunction

  function automatic void emit_end(input logic [3:0] cls);
    out_word_t w;
    if (words_this_item < MAX_WORDS_PER_ITEM) begin
      w.item_kind = KIND_END;
      w.lexeme_byte = '0;
      w.token_class = cls;
      w.last_of_input = 1'b0;
      expected_words.push_back(w);
      words_this_item++;
    end
    lexeme_open = 1'b0;
  endfunction

  // Returns 1 when the byte is consumed, 0 when it must be run again in the new state.
  function automatic logic lex_pass(input logic [7:0] c);
    logic [7:0] quote;
    logic [3:0] cls;
    case (lx_state)
      LX_START: begin
        if (c == CH_SLASH) begin
          emit_byte(c);
          lx_state = LX_SLASH;
        end else if (c == CH_DQUOTE) begin
          emit_byte(c);
          lx_state = LX_DQ;
        end else if (c == CH_SQUOTE) begin
          emit_byte(c);
          lx_state = LX_SQ;
        end else if (c == CH_LF) begin
          emit_byte(c);
          emit_end(CL_NEWLINE);
        end else if (blank_byte(c)) begin
          emit_byte(c);
          lx_state = LX_SPACE;
        end else if (word_byte(c)) begin
          emit_byte(c);
          lx_state = LX_SYMBOL;
        end else if (c != CH_NUL) begin
          emit_byte(c);
          emit_end(CL_OPERATOR);
        end
        return 1'b1;
      end
      LX_SLASH: begin
        if (c == CH_SLASH) begin
          emit_byte(c);
          lx_state = LX_LINE_CMT;
          return 1'b1;
        end
        if (c == CH_STAR) begin
          emit_byte(c);
          emit_end(CL_CBEGIN);
          lx_state = LX_BLOCK;
          return 1'b1;
        end
        emit_end(CL_OPERATOR);
        lx_state = LX_START;
        return 1'b0;
      end
      LX_LINE_CMT: begin
        if (c == CH_LF || c == CH_NUL) begin
          emit_end(CL_LINECMT);
          lx_state = LX_START;
          return c == CH_NUL;
        end
        emit_byte(c);
        return 1'b1;
      end
      LX_BLOCK: begin
        if (c == CH_STAR) begin
          lx_state = LX_BLOCK_STAR;
        end else if (c == CH_LF) begin
          if (lexeme_open) begin
            emit_end(CL_COMMENT);
            return 1'b0;
          end
          emit_byte(c);
          emit_end(CL_NEWLINE);
        end else if (c == CH_NUL) begin
          lx_state = LX_START;
        end else begin
          emit_byte(c);
        end
        return 1'b1;
      end
      LX_BLOCK_STAR: begin
        if (c == CH_STAR) begin
          emit_byte(CH_STAR);
          return 1'b1;
        end
        if (c == CH_SLASH) begin
          if (lexeme_open) begin
            emit_end(CL_COMMENT);
            return 1'b0;
          end
          emit_byte(CH_STAR);
          emit_byte(CH_SLASH);
          emit_end(CL_CEND);
          lx_state = LX_START;
          return 1'b1;
        end
        if (c == CH_LF || c == CH_NUL) begin
          emit_byte(CH_STAR);
          emit_end(CL_COMMENT);
          lx_state = (c == CH_LF) ? LX_BLOCK : LX_START;
          return 1'b0;
        end
        emit_byte(c);
        lx_state = LX_BLOCK;
        return 1'b1;
      end
      LX_DQ, LX_SQ: begin
        quote = (lx_state == LX_DQ) ? CH_DQUOTE : CH_SQUOTE;
        cls = (lx_state == LX_DQ) ? CL_DQ : CL_SQ;
        if (c == quote) begin
          emit_byte(c);
          emit_end(cls);
          lx_state = LX_START;
        end else if (c == CH_LF || c == CH_NUL) begin
          emit_end(cls);
          lx_state = LX_START;
          return c == CH_NUL;
        end else if (c == CH_BSLASH) begin
          emit_byte(c);
          lx_state = (lx_state == LX_DQ) ? LX_DQ_ESC : LX_SQ_ESC;
        end else begin
          emit_byte(c);
        end
        return 1'b1;
      end
      LX_SPACE: begin
        if (blank_byte(c)) begin
          emit_byte(c);
          return 1'b1;
        end
        emit_end(CL_SPACE);
        lx_state = LX_START;
        return 1'b0;
      end
      LX_SYMBOL: begin
        if (word_byte(c)) begin
          emit_byte(c);
          return 1'b1;
        end
        emit_end(CL_SYMBOL);
        lx_state = LX_START;
        return 1'b0;
      end
      default: begin
        cls = (lx_state == LX_DQ_ESC) ? CL_DQ : CL_SQ;
        if (c == CH_LF || c == CH_NUL) begin
          emit_end(cls);
          lx_state = LX_START;
          return c == CH_NUL;
        end
        emit_byte(c);
        lx_state = (lx_state == LX_DQ_ESC) ? LX_DQ : LX_SQ;
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void lex_feed(input logic [7:0] c);
    for (int k = 0; k < 3; k++) begin
      if (lex_pass(c)) break;
    end
  endfunction

  function automatic void predict_tokens(input in_word_t w);
    int first;
    out_word_t tail;
    words_this_item = 0;
    first = expected_words.size();
    if (w.end_of_stream) begin
      if (bs_held) begin
        bs_held = 1'b0;
        lex_feed(CH_BSLASH);
      end
      lx_state = LX_START;
      lexeme_open = 1'b0;
    end else if (w.char_in == CH_CR) begin
    end else if (bs_held) begin
      bs_held = 1'b0;
      if (w.char_in != CH_LF) begin
        lex_feed(CH_BSLASH);
        if (w.char_in == CH_BSLASH) bs_held = 1'b1;
        else lex_feed(w.char_in);
      end
    end else if (w.char_in == CH_BSLASH) begin
      bs_held = 1'b1;
    end else begin
      lex_feed(w.char_in);
    end
    if (expected_words.size() > first) begin
      tail = expected_words.pop_back();
      tail.last_of_input = 1'b1;
      expected_words.push_back(tail);
    end
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("%0t ns: result word %0d: %s", $time, results_seen, what);
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch($sformatf("arrived with nothing expected (%h)", got));
    end else begin
      want = expected_words.pop_front();
      if (got.item_kind !== want.item_kind)
        report_mismatch($sformatf("item_kind %b, expected %b", got.item_kind, want.item_kind));
      if (got.lexeme_byte !== want.lexeme_byte)
        report_mismatch($sformatf("lexeme_byte %h, expected %h",
                                  got.lexeme_byte, want.lexeme_byte));
      if (got.token_class !== want.token_class)
        report_mismatch($sformatf("token_class %0d, expected %0d",
                                  got.token_class, want.token_class));
      if (got.last_of_input !== want.last_of_input)
        report_mismatch($sformatf("last_of_input %b, expected %b",
                                  got.last_of_input, want.last_of_input));
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lx_state = LX_START;
      bs_held = 1'b0;
      lexeme_open = 1'b0;
      expected_words.delete();
    end else begin
      if (in_valid && in_ready) predict_tokens(in_data);
      if (out_valid && out_ready) check_result(out_data);
    end
    pending_words <= expected_words.size();
    fail_count <= mismatch_count;
  end

endmodule

// File: tb/c_source_lexer_tb.sv
// Top of the source lexer testbench: clock, reset, directed and random source text,
// bursty input and stalling output. Depends on cslx_pkg, cslx_token_checker, c_source_lexer.
`timescale 1ns / 1ps
module c_source_lexer_tb;
  import cslx_pkg::*;

  localparam int RANDOM_ITEMS = 320;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_word_t  in_data = '0;
  logic      in_ready;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  int        pending_words;
  int        fail_count;

  int    items_sent = 0;
  int    burst_left = 0;
  int    ready_mode = 0;
  int    ready_left = 0;
  string op_chars = "+-*&|<>=!;,.(){}[]?:%^~#";

  c_source_lexer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  cslx_token_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .pending_words(pending_words),
    .fail_count   (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("c_source_lexer regression: fail");
    $finish;
  end

  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(16, 96);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 4) == 0);
      default: out_ready <= (ready_left % 4 != 0);
    endcase
  end

  task automatic send_word(input logic [7:0] c, input logic eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= '{char_in: c, end_of_stream: eos};
    do @(posedge clk); while (!in_ready);
    if (eos || c != CH_CR) items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] c);
    send_word(c, 1'b0);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    burst_left = 0;
  endtask

  function automatic logic [7:0] pick_word_char();
    case ($urandom_range(0, 3))
      0: return 8'(8'h61 + $urandom_range(0, 25));
      1: return 8'(8'h41 + $urandom_range(0, 25));
      2: return 8'(8'h30 + $urandom_range(0, 9));
      default: return CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] pick_text_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  task automatic send_quoted(input logic [7:0] quote);
    int n;
    n = $urandom_range(0, 8);
    send_byte(quote);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) send_byte(CH_BSLASH);
      send_byte(pick_text_byte());
    end
    if ($urandom_range(0, 9) != 0) send_byte(quote);
  endtask

  task automatic send_fragment();
    int n;
    n = $urandom_range(1, 8);
    case ($urandom_range(0, 19))
      0, 1, 2: repeat (n) send_byte(pick_word_char());
      3, 4: repeat (n) send_byte(($urandom_range(0, 2) == 0) ? CH_TAB : CH_SPACE);
      5, 6: begin
        if ($urandom_range(0, 2) == 0) send_byte(CH_CR);
        send_byte(CH_LF);
      end
      7, 8: begin
        if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(128, 255)));
        else send_byte(op_chars[$urandom_range(0, op_chars.len() - 1)]);
      end
      9: send_quoted(CH_DQUOTE);
      10: send_quoted(CH_SQUOTE);
      11: begin
        send_byte(CH_SLASH);
        send_byte(CH_SLASH);
        repeat (n) send_byte(pick_text_byte());
        send_byte(CH_LF);
      end
      12, 13: begin
        send_byte(CH_SLASH);
        send_byte(CH_STAR);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0, 1: send_byte(CH_STAR);
            2: send_byte(CH_LF);
            3: send_byte(CH_NUL);
            default: send_byte(pick_text_byte());
          endcase
        end
        if ($urandom_range(0, 9) != 0) begin
          send_byte(CH_STAR);
          send_byte(CH_SLASH);
        end
      end
      14: send_byte(8'($urandom_range(0, 255)));
      15: begin
        send_byte(CH_BSLASH);
        if ($urandom_range(0, 1) == 0) send_byte(CH_CR);
        send_byte(CH_LF);
      end
      16: begin
        send_byte(CH_BSLASH);
        send_byte(CH_BSLASH);
      end
      17: send_byte(CH_NUL);
      18: begin
        if ($urandom_range(0, 1) == 0) send_byte(CH_BSLASH);
        send_word(8'($urandom_range(0, 255)), 1'b1);
      end
      default: send_byte(CH_CR);
    endcase
  endtask

  initial begin
    int next_pause;
    int end_count;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(CH_NUL);    send_byte(8'hFF);     send_byte("a");       send_byte(CH_TAB);
    send_byte(CH_BSLASH); send_byte(CH_LF);     send_byte(CH_BSLASH); send_byte(CH_BSLASH);
    send_byte(CH_DQUOTE); send_byte(CH_BSLASH); send_byte(CH_CR);     send_byte(CH_DQUOTE);
    send_byte(CH_DQUOTE); send_byte(CH_SQUOTE); send_byte(CH_LF);     send_byte(CH_SLASH);
    send_byte(CH_STAR);   send_byte(CH_STAR);   send_byte(CH_SLASH);  send_byte(CH_SLASH);
    send_byte(CH_STAR);   send_byte("q");       send_byte(CH_STAR);   send_byte(CH_NUL);
    send_byte(CH_SLASH);  send_byte(CH_SLASH);  send_byte(CH_NUL);    send_byte(CH_BSLASH);
    send_word(8'h5A, 1'b1);
    wait_for_results();

    next_pause = items_sent + 120;
    end_count = items_sent + RANDOM_ITEMS;
    while (items_sent < end_count) begin
      send_fragment();
      if (items_sent >= next_pause) begin
        wait_for_results();
        next_pause += 120;
      end
    end
    send_word(8'h00, 1'b1);
    wait_for_results();
    repeat (40) @(posedge clk);

    if (fail_count == 0)
      $display("c_source_lexer regression: pass");
    else
      $display("c_source_lexer regression: fail");
    $finish;
  end

endmodule
